// ===== rtl/core/lftp_pkg.sv =====
// Shared types and constants for the tag frame parser.
// Used by the front end, the back end and the top level; depends on nothing.
package lftp_pkg;

  localparam logic [7:0] START_BYTE = 8'h02;
  localparam logic [7:0] END_BYTE   = 8'h03;

  // Frame positions, counted from the start byte at position 0
  localparam int unsigned FRAME_LEN   = 14;
  localparam logic [3:0]  LAST_POS    = 4'(FRAME_LEN - 1);
  localparam logic [3:0]  ID_LAST_POS = 4'd10;
  localparam logic [3:0]  CHK_LAST_POS = 4'd12;

  localparam int unsigned ID_W  = 40;
  localparam int unsigned CHK_W = 8;

  localparam int unsigned CMD_DEPTH_DEF = 2;
  localparam int unsigned RES_DEPTH_DEF = 2;

  typedef enum logic [2:0] {
    OP_START   = 3'd0,
    OP_FIRST   = 3'd1,
    OP_ID_PAIR = 3'd2,
    OP_CHK_PAIR = 3'd3,
    OP_END_OK  = 3'd4,
    OP_END_BAD = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_MISMATCH = 2'd1,
    ST_BAD_LEN  = 2'd2
  } status_e;

  typedef struct packed {
    op_e        op;
    logic [3:0] nib;
    logic       nib_ok;
  } cmd_t;

  typedef struct packed {
    status_e           status;
    logic [ID_W-1:0]   tag_id;
    logic [CHK_W-1:0]  computed_check;
    logic [CHK_W-1:0]  received_check;
  } res_t;

endpackage

// ===== rtl/core/lftp_fifo.sv =====
// Small flop-based queue with a fill count, used between the stages.
// Depends on nothing; width and depth come from parameters.
module lftp_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("fifo fill count beyond depth");
`endif

endmodule

// ===== rtl/core/lftp_front.sv =====
// Front end: tracks frame position and classifies each byte into a command.
// Depends on lftp_pkg.
module lftp_front
  import lftp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] rx_byte_i,
  output logic       cmd_valid_o,
  output cmd_t       cmd_o
);

  logic       in_frame_q, in_frame_d;
  logic [3:0] cnt_q, cnt_d;
  logic [7:0] dig_off, low_off, up_off;
  logic [3:0] nib;
  logic       nib_ok;

  assign dig_off = rx_byte_i - 8'h30;
  assign low_off = rx_byte_i - 8'h57;
  assign up_off  = rx_byte_i - 8'h37;

  // Hex value of the byte, flagged when it is not a hex digit
  always_comb begin
    nib_ok = 1'b1;
    nib    = dig_off[3:0];
    if (rx_byte_i >= 8'h30 && rx_byte_i <= 8'h39) begin
      nib = dig_off[3:0];
    end else if (rx_byte_i >= 8'h61 && rx_byte_i <= 8'h66) begin
      nib = low_off[3:0];
    end else if (rx_byte_i >= 8'h41 && rx_byte_i <= 8'h46) begin
      nib = up_off[3:0];
    end else begin
      nib_ok = 1'b0;
    end
  end

  always_comb begin
    in_frame_d   = in_frame_q;
    cnt_d        = cnt_q;
    cmd_valid_o  = 1'b0;
    cmd_o.op     = OP_START;
    cmd_o.nib    = nib;
    cmd_o.nib_ok = nib_ok;
    if (accept_i) begin
      if (rx_byte_i == START_BYTE) begin
        in_frame_d  = 1'b1;
        cnt_d       = 4'd1;
        cmd_valid_o = 1'b1;
      end else if (in_frame_q) begin
        cnt_d = cnt_q + 1'b1;
        if (rx_byte_i == END_BYTE) begin
          in_frame_d  = 1'b0;
          cmd_valid_o = 1'b1;
          cmd_o.op    = (cnt_q == LAST_POS) ? OP_END_OK : OP_END_BAD;
        end else if (cnt_q <= CHK_LAST_POS) begin
          cmd_valid_o = 1'b1;
          if (cnt_q[0]) begin
            cmd_o.op = OP_FIRST;
          end else if (cnt_q <= ID_LAST_POS) begin
            cmd_o.op = OP_ID_PAIR;
          end else begin
            cmd_o.op = OP_CHK_PAIR;
          end
        end else begin
          // no end byte where one was due: drop the frame
          in_frame_d = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      cnt_q      <= '0;
    end else begin
      in_frame_q <= in_frame_d;
      cnt_q      <= cnt_d;
    end
  end

`ifndef SYNTH
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_frame_q |-> (cnt_q >= 4'd1 && cnt_q <= LAST_POS))
    else $error("frame position out of range while receiving");
  a_end_ok_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_valid_o && cmd_o.op == OP_END_OK) |-> (cnt_q == LAST_POS))
    else $error("complete frame reported at wrong position");
  a_start_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && rx_byte_i == START_BYTE) |=> (in_frame_q && cnt_q == 4'd1))
    else $error("start byte did not restart the frame");
`endif

endmodule

// ===== rtl/core/lftp_back.sv =====
// Back end: carries out commands on the ID and checksum accumulators and
// builds result items. Depends on lftp_pkg.
module lftp_back
  import lftp_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cmd_empty_i,
  input  cmd_t cmd_i,
  output logic cmd_pop_o,
  input  logic res_full_i,
  output logic res_push_o,
  output res_t res_o
);

  logic [3:0]      first_nib_q;
  logic            first_ok_q;
  logic [ID_W-1:0] id_q;
  logic [7:0]      xor_q, chk_q;
  logic [7:0]      pair_val;
  logic            is_end;

  assign is_end     = (cmd_i.op == OP_END_OK) || (cmd_i.op == OP_END_BAD);
  assign cmd_pop_o  = !cmd_empty_i && (!is_end || !res_full_i);
  assign res_push_o = cmd_pop_o && is_end;

  // Leading valid digits of the pair
  always_comb begin
    if (!first_ok_q) begin
      pair_val = 8'h00;
    end else if (!cmd_i.nib_ok) begin
      pair_val = {4'h0, first_nib_q};
    end else begin
      pair_val = {first_nib_q, cmd_i.nib};
    end
  end

  always_comb begin
    if (cmd_i.op == OP_END_OK) begin
      res_o.status         = (xor_q == chk_q) ? ST_OK : ST_MISMATCH;
      res_o.tag_id         = id_q;
      res_o.computed_check = xor_q;
      res_o.received_check = chk_q;
    end else begin
      res_o.status         = ST_BAD_LEN;
      res_o.tag_id         = '0;
      res_o.computed_check = '0;
      res_o.received_check = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_nib_q <= '0;
      first_ok_q  <= 1'b0;
      id_q        <= '0;
      xor_q       <= '0;
      chk_q       <= '0;
    end else if (cmd_pop_o) begin
      unique case (cmd_i.op)
        OP_START: begin
          first_nib_q <= '0;
          first_ok_q  <= 1'b0;
          id_q        <= '0;
          xor_q       <= '0;
          chk_q       <= '0;
        end
        OP_FIRST: begin
          first_nib_q <= cmd_i.nib;
          first_ok_q  <= cmd_i.nib_ok;
        end
        OP_ID_PAIR: begin
          id_q  <= {id_q[ID_W-9:0], pair_val};
          xor_q <= xor_q ^ pair_val;
        end
        OP_CHK_PAIR: begin
          chk_q <= pair_val;
        end
        OP_END_OK, OP_END_BAD: begin
        end
        default: begin
        end
      endcase
    end
  end

`ifndef SYNTH
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o |-> !res_full_i)
    else $error("result written into a full queue");
  a_start_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_pop_o && cmd_i.op == OP_START) |=> (xor_q == 8'h00 && id_q == '0))
    else $error("start did not clear the accumulators");
`endif

endmodule

// ===== rtl/core/lf_tag_ascii_frame_parser_top.sv =====
// Tag reader frame parser: STX/ETX framed ASCII hex ID with XOR checksum.
// Input channel: present rx_byte_i with push; a byte transfers on a rising
//   edge with push high and full low. Bytes outside a frame are discarded.
// Result channel: while empty is low the oldest result sits on status_o,
//   tag_id_o, computed_check_o and received_check_o; it transfers on a
//   rising edge with pop high and empty low.
// A result appears only for an end byte inside a frame: status 0 or 1 for a
//   full 14-byte frame, status 2 with zero fields for a short one. A frame of
//   14 bytes with no end byte is dropped without a result.
// Throughput: one byte per cycle while full is low, set by the classifier in the
//   front end and the accumulator update in the back end.
// The end byte's command is registered in the command queue and then its result in
//   the result queue; empty falls once the result is there.
// Reset (rst_ni low, asynchronous) empties both queues and leaves the parser
//   outside a frame. When pop stays low the result queue fills, the back end
//   holds its command, the command queue fills and full rises.
// Depends on lftp_pkg, lftp_front, lftp_fifo and lftp_back.
module lf_tag_ascii_frame_parser_top
  import lftp_pkg::*;
#(
  parameter int unsigned CMD_DEPTH = CMD_DEPTH_DEF,
  parameter int unsigned RES_DEPTH = RES_DEPTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic [7:0]         rx_byte_i,
  output logic               empty,
  input  logic               pop,
  output logic [1:0]         status_o,
  output logic [ID_W-1:0]    tag_id_o,
  output logic [CHK_W-1:0]   computed_check_o,
  output logic [CHK_W-1:0]   received_check_o
);

  logic                    accept;
  logic                    cmd_valid;
  cmd_t                    front_cmd, back_cmd;
  logic [$bits(cmd_t)-1:0] back_cmd_raw;
  logic                    cmd_empty, cmd_pop;
  logic                    res_full, res_push;
  res_t                    back_res, out_res;
  logic [$bits(res_t)-1:0] out_res_raw;

  assign accept = push && !full;

  lftp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .rx_byte_i   (rx_byte_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (front_cmd)
  );

  lftp_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_valid),
    .data_i  (front_cmd),
    .full_o  (full),
    .pop_i   (cmd_pop),
    .data_o  (back_cmd_raw),
    .empty_o (cmd_empty)
  );

  assign back_cmd = back_cmd_raw;

  lftp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_empty_i (cmd_empty),
    .cmd_i       (back_cmd),
    .cmd_pop_o   (cmd_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (back_res)
  );

  lftp_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (RES_DEPTH)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (back_res),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (out_res_raw),
    .empty_o (empty)
  );

  assign out_res          = out_res_raw;
  assign status_o         = out_res.status;
  assign tag_id_o         = out_res.tag_id;
  assign computed_check_o = out_res.computed_check;
  assign received_check_o = out_res.received_check;

endmodule
